### sv/snq_pkg.sv
// Shared constants, scale table and helper functions of the scale note quantizer.
`timescale 1ns / 1ps

package snq_pkg;

    localparam int PITCH_CLASSES = 12;
    localparam int MAX_DISTANCE  = 6;
    localparam int SCALE_COUNT   = 14;

    localparam logic [11:0] FULL_MASK = 12'hFFF;
    localparam logic [6:0]  NOTE_MAX  = 7'd127;

    localparam logic [3:0] SCALE_RESET = 4'd1;
    localparam logic [3:0] ROOT_RESET  = 4'd0;

    typedef enum logic [1:0] {
        CFG_SCALE_SELECT = 2'd0,
        CFG_ROOT_PITCH   = 2'd1
    } cfg_index_t;

    function automatic logic [11:0] scale_mask(input logic [3:0] sel);
        logic [11:0] m;
        case (sel)
            4'd0:    m = 12'hFFF;
            4'd1:    m = 12'hAB5;
            4'd2:    m = 12'h5AD;
            4'd3:    m = 12'h9AD;
            4'd4:    m = 12'hAAD;
            4'd5:    m = 12'h6AD;
            4'd6:    m = 12'h5AB;
            4'd7:    m = 12'hAD5;
            4'd8:    m = 12'h6B5;
            4'd9:    m = 12'h56B;
            4'd10:   m = 12'h295;
            4'd11:   m = 12'h4A9;
            4'd12:   m = 12'h4E9;
            4'd13:   m = 12'h555;
            default: m = FULL_MASK;
        endcase
        return m;
    endfunction

    function automatic logic [11:0] rotl12(input logic [11:0] m, input logic [3:0] r);
        logic [23:0] w;
        w = {m, m} << r;
        return w[23:12];
    endfunction

    function automatic logic [11:0] rotr12(input logic [11:0] m, input logic [3:0] r);
        logic [23:0] w;
        w = {m, m} >> r;
        return w[11:0];
    endfunction

    // Remainder by 12 through a quotient from the reciprocal 43/512, exact for 0..127.
    function automatic logic [3:0] mod12(input logic [6:0] n);
        logic [12:0] p;
        logic [3:0]  q;
        logic [6:0]  qm;
        p  = {6'd0, n} * 13'd43;
        q  = p[12:9];
        qm = 7'({q, 3'b000} + {1'b0, q, 2'b00});
        return 4'(n - qm);
    endfunction

endpackage

### sv/scale_note_quantizer_unit.sv
// Scale note quantizer: a four-stage pipeline that moves notes to the nearest scale member.
//
// The s_ channel takes one MIDI note word per cycle while s_tready is high, in
// s_tdata[6:0]; the m_ channel returns the quantized note in m_tdata[6:0], one result
// word for each input word, in order. The cfg channel writes the scale select (index 0)
// and the root pitch (index 1); it is always ready. The user must write it only while the
// pipeline is empty; the block itself does not enforce this. Each word passes the four
// registered stages, with m_tvalid driven from the last; while the receiver accepts, the
// throughput is one word per cycle: the stages are table lookup and rotation, rotation to
// the note's pitch class, nearest-member search, and the saturating add.
// A synchronous active-low reset empties the pipeline and restores the major scale
// on root 0. When the receiver stalls, each stage holds its word and s_tready falls
// once all four stages are full; nothing is lost or repeated.
`timescale 1ns / 1ps

module scale_note_quantizer_unit
    import snq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [6:0] note_in, [7] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] note_out, [7] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_addr,
    input  logic [3:0] cfg_data
);

    logic [3:0] scale_reg;
    logic [3:0] root_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [6:0]  note1_reg, note2_reg, note3_reg, note4_reg;
    logic [3:0]  pc1_reg;
    logic [11:0] mask1_reg;
    logic [11:0] rel2_reg;
    logic        pass2_reg;
    logic signed [3:0] delta3_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [3:0]  root_mod;
    logic [11:0] mask_next;
    logic [11:0] rel_next;
    logic        pass_next;
    logic signed [3:0] delta_next;
    logic signed [8:0] sum;
    logic [6:0]  note_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            root_reg  <= ROOT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_SCALE_SELECT: scale_reg <= cfg_data;
                CFG_ROOT_PITCH:   root_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        root_mod  = (root_reg >= 4'(PITCH_CLASSES)) ? root_reg - 4'(PITCH_CLASSES) : root_reg;
        mask_next = rotl12(scale_mask(scale_reg), root_mod);
    end

    always_comb begin
        rel_next  = rotr12(mask1_reg, pc1_reg);
        pass_next = (mask1_reg == FULL_MASK) || (mask1_reg == 12'd0) || rel_next[0];
    end

    always_comb begin
        delta_next = 4'sd0;
        if (!pass2_reg) begin
            for (int d = MAX_DISTANCE; d >= 1; d--) begin
                if (rel2_reg[PITCH_CLASSES - d]) begin
                    delta_next = -(4'(d));
                end
                if (rel2_reg[d]) begin
                    delta_next = 4'(d);
                end
            end
        end
    end

    always_comb begin
        sum = $signed({2'b00, note3_reg}) + 9'(delta3_reg);
        if (sum < 0) begin
            note_next = 7'd0;
        end else if (sum > $signed({2'b00, NOTE_MAX})) begin
            note_next = NOTE_MAX;
        end else begin
            note_next = sum[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            note1_reg <= s_tdata[6:0];
            pc1_reg   <= mod12(s_tdata[6:0]);
            mask1_reg <= mask_next;
        end
        if (rdy2 && v1_reg) begin
            note2_reg <= note1_reg;
            rel2_reg  <= rel_next;
            pass2_reg <= pass_next;
        end
        if (rdy3 && v2_reg) begin
            note3_reg  <= note2_reg;
            delta3_reg <= delta_next;
        end
        if (rdy4 && v3_reg) begin
            note4_reg <= note_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {1'b0, note4_reg};

`ifndef NO_ASSERTIONS
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Pipeline not empty after reset.");
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> pc1_reg < 4'(PITCH_CLASSES))
        else $error("Pitch class out of range.");
    a_delta_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (delta3_reg >= -4'sd6) && (delta3_reg <= 4'sd6))
        else $error("Search distance out of range.");
    a_pass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && rdy3 && pass2_reg) |=> delta3_reg == 4'sd0)
        else $error("Scale member was moved.");
`endif

endmodule
